>>> rtl/cbt_pkg.sv
// Package of constants, types and weight tables for the cubic Bezier tessellator.
`default_nettype none

package cbt_pkg;

    // Run length as configured, and as used after clamping to the legal range.
    localparam int POINTS_PER_CURVE = 50;
    localparam int RUN_LEN = (POINTS_PER_CURVE < 2) ? 2 :
                             ((POINTS_PER_CURVE > 64) ? 64 : POINTS_PER_CURVE);

    // Field widths.
    localparam int COORD_W = 16;
    localparam int IDX_W   = 6;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int TAB_LEN = 1 << IDX_W;

    // Index of the final point of a run.
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RUN_LEN - 1);

    // Parameter t in unsigned Q1.16, stepped by a rounded reciprocal of N-1.
    localparam longint T_ONE  = 65536;
    localparam longint T_STEP = (T_ONE + (RUN_LEN - 1) / 2) / (RUN_LEN - 1);

    // Blend weights are Q48 and reach exactly 2^48, so they need 49 bits.
    localparam int WGT_W  = 49;
    localparam int WLO_W  = 25;
    localparam int WHI_W  = WGT_W - WLO_W;
    localparam int PHI_W  = WHI_W + 1 + DIFF_W;
    localparam int PLO_W  = WLO_W + 1 + DIFF_W;
    localparam int SUM_W  = 68;
    localparam int FRAC_W = 48;

    typedef logic [TAB_LEN-1:0][WGT_W-1:0] wgt_tab_t;

    // Weight of the start side for x: u^3 + 3u^2 t = u^2 (1 + 2t).
    function automatic wgt_tab_t build_wx();
        wgt_tab_t tab;
        longint   t;
        longint   u;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            t = (i == RUN_LEN - 1) ? T_ONE : longint'(i) * T_STEP;
            if (t > T_ONE)
            begin
                t = T_ONE;
            end
            u = T_ONE - t;
            tab[i] = WGT_W'(u * u * (T_ONE + 2 * t));
        end
        return tab;
    endfunction

    // Weight of the start side for y: u^3 + 3u t^2 = u (u^2 + 3t^2).
    function automatic wgt_tab_t build_wy();
        wgt_tab_t tab;
        longint   t;
        longint   u;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            t = (i == RUN_LEN - 1) ? T_ONE : longint'(i) * T_STEP;
            if (t > T_ONE)
            begin
                t = T_ONE;
            end
            u = T_ONE - t;
            tab[i] = WGT_W'(u * (u * u + 3 * t * t));
        end
        return tab;
    endfunction

    localparam wgt_tab_t WX_TAB = build_wx();
    localparam wgt_tab_t WY_TAB = build_wy();

endpackage

`default_nettype wire

>>> rtl/cubic_bezier_tessellator.sv
// Top level of the cubic Bezier tessellator: point generator and three-stage blend pipeline.
//
// Channel  Dir  Signals                    Contents
// s_       in   tvalid tready tdata[63:0]  one curve: start and end point
// m_       out  tvalid tready tdata[39:0]  one curve point, tlast on the final one
//                tlast
//
// Each curve yields 50 points, one per cycle while m_ is not stalled; the point
// counter of the generator sets that figure.
// After the curve's transaction, its first point passes through stages 1, 2 and 3
// and is then presented in the output register. The next curve is taken in the
// cycle the previous run's final point is generated. Reset empties the generator
// and pipeline.
// A stall on m_ holds every stage; nothing is lost or repeated.
`default_nettype none

module cubic_bezier_tessellator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // point_x[15:0], point_y[31:16], sample_index[37:32], zero[39:38]
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);

    localparam int CW = cbt_pkg::COORD_W;
    localparam int IW = cbt_pkg::IDX_W;
    localparam int DW = cbt_pkg::DIFF_W;
    localparam int WW = cbt_pkg::WGT_W;
    localparam int LW = cbt_pkg::WLO_W;
    localparam int SW = cbt_pkg::SUM_W;
    localparam int FW = cbt_pkg::FRAC_W;

    // Generator: held end points and the running point index.
    logic                 busy_reg, busy_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic signed [CW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    // Whole pipeline advances when the output register is free or drained.
    logic advance;
    logic gen_last;
    logic accept;

    assign advance  = !m_tvalid || m_tready;
    assign gen_last = (idx_reg == cbt_pkg::LAST_IDX);
    assign s_tready = advance && (!busy_reg || gen_last);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (advance && busy_reg)
        begin
            if (gen_last)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= s_tdata[15:0];
            sy_reg <= s_tdata[31:16];
            ex_reg <= s_tdata[47:32];
            ey_reg <= s_tdata[63:48];
        end
    end

    // Stage 1: weight lookup and end-point differences.
    logic                 v1_reg;
    logic [WW-1:0]        wx1_reg, wy1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg;
    logic signed [CW-1:0] ex1_reg, ey1_reg;
    logic [IW-1:0]        idx1_reg;
    logic                 last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wx1_reg   <= cbt_pkg::WX_TAB[idx_reg];
            wy1_reg   <= cbt_pkg::WY_TAB[idx_reg];
            dx1_reg   <= DW'(sx_reg) - DW'(ex_reg);
            dy1_reg   <= DW'(sy_reg) - DW'(ey_reg);
            ex1_reg   <= ex_reg;
            ey1_reg   <= ey_reg;
            idx1_reg  <= idx_reg;
            last1_reg <= gen_last;
        end
    end

    // Stage 2: weight times difference, split into high and low partial products.
    logic                                  v2_reg;
    logic signed [cbt_pkg::PHI_W-1:0]      pxh2_reg, pyh2_reg;
    logic signed [cbt_pkg::PLO_W-1:0]      pxl2_reg, pyl2_reg;
    logic signed [CW-1:0]                  ex2_reg, ey2_reg;
    logic [IW-1:0]                         idx2_reg;
    logic                                  last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pxh2_reg  <= $signed({1'b0, wx1_reg[WW-1:LW]}) * dx1_reg;
            pxl2_reg  <= $signed({1'b0, wx1_reg[LW-1:0]}) * dx1_reg;
            pyh2_reg  <= $signed({1'b0, wy1_reg[WW-1:LW]}) * dy1_reg;
            pyl2_reg  <= $signed({1'b0, wy1_reg[LW-1:0]}) * dy1_reg;
            ex2_reg   <= ex1_reg;
            ey2_reg   <= ey1_reg;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
        end
    end

    // Stage 3: join partial products, round to nearest, add the end coordinate.
    logic signed [SW-1:0] sum_x, sum_y;
    logic [CW-1:0]        px_next, py_next;

    always_comb
    begin
        sum_x   = (SW'(pxh2_reg) <<< LW) + SW'(pxl2_reg) + (SW'(1) <<< (FW - 1));
        sum_y   = (SW'(pyh2_reg) <<< LW) + SW'(pyl2_reg) + (SW'(1) <<< (FW - 1));
        px_next = ex2_reg + sum_x[FW+CW-1:FW];
        py_next = ey2_reg + sum_y[FW+CW-1:FW];
    end

    logic          v3_reg;
    logic [CW-1:0] px3_reg, py3_reg;
    logic [IW-1:0] idx3_reg;
    logic          last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px3_reg   <= px_next;
            py3_reg   <= py_next;
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;
        end
    end

    // Output transaction.
    assign m_tvalid = v3_reg;
    assign m_tdata  = {2'b00, idx3_reg, py3_reg, px3_reg};
    assign m_tlast  = last3_reg;

    // Checks on run framing.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[37:32] == cbt_pkg::LAST_IDX)
        else $error("final point carries the wrong index");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> busy_reg && idx_reg == '0)
        else $error("accepted curve did not restart the generator");

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[37:32] == $past(m_tdata[37:32]) + 6'd1)
        else $error("points of a run are not contiguous");

    a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tdata[37:32] == '0 |-> 1'b0)
        else $error("run ended at index zero");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the cubic Bezier tessellator.
`default_nettype none

module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // point_x[15:0], point_y[31:16], sample_index[37:32], zero[39:38]
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Traffic shaping: idling on both sides is switched off near the end.
    bit          idling_on;
    int          stall_left;

    // One expected curve point.
    typedef struct packed
    {
        logic [cbt_pkg::COORD_W-1:0] x;
        logic [cbt_pkg::COORD_W-1:0] y;
        logic [cbt_pkg::IDX_W-1:0]   idx;
        logic                        last;
    } curve_point_t;

    // Holds the points still owed by the block and checks each one that leaves it.
    class curve_scoreboard;
        curve_point_t pending_points[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        // Blend one coordinate with the four Bernstein weights; coordinates are
        // biased to unsigned so that the whole sum stays in 64 bits.
        function bit [15:0] blend_coord(input bit [63:0] w0, input bit [63:0] w1,
                                        input bit [63:0] w2, input bit [63:0] w3,
                                        input bit [15:0] a, input bit [15:0] b,
                                        input bit [15:0] c, input bit [15:0] d);
            bit [63:0] sum;
            bit [63:0] rounded;
            sum = w0 * {48'd0, a ^ 16'h8000} + w1 * {48'd0, b ^ 16'h8000}
                + w2 * {48'd0, c ^ 16'h8000} + w3 * {48'd0, d ^ 16'h8000};
            rounded = (sum + (64'd1 << 47)) >> 48;
            return rounded[15:0] ^ 16'h8000;
        endfunction

        // An accepted curve: work out every point of its run.
        function void note_curve(input logic [63:0] curve);
            bit [15:0]    sx;
            bit [15:0]    sy;
            bit [15:0]    ex;
            bit [15:0]    ey;
            bit [63:0]    n;
            bit [63:0]    t_step;
            bit [63:0]    t;
            bit [63:0]    u;
            bit [63:0]    w0;
            bit [63:0]    w1;
            bit [63:0]    w2;
            bit [63:0]    w3;
            curve_point_t pt;
            sx = curve[15:0];
            sy = curve[31:16];
            ex = curve[47:32];
            ey = curve[63:48];
            n = 64'(cbt_pkg::RUN_LEN);
            t_step = (64'd65536 + (n - 1) / 2) / (n - 1);
            for (int i = 0; i < cbt_pkg::RUN_LEN; i++)
            begin
                // The final point sits exactly at t = 1.
                t = (i == cbt_pkg::RUN_LEN - 1) ? 64'd65536 : 64'(i) * t_step;
                if (t > 64'd65536)
                begin
                    t = 64'd65536;
                end
                u = 64'd65536 - t;
                w0 = u * u * u;
                w1 = 3 * u * u * t;
                w2 = 3 * u * t * t;
                w3 = t * t * t;
                // Inner control points are (start x, end y) and (end x, start y).
                pt.x = blend_coord(w0, w1, w2, w3, sx, sx, ex, ex);
                pt.y = blend_coord(w0, w1, w2, w3, sy, ey, sy, ey);
                pt.idx = cbt_pkg::IDX_W'(i);
                pt.last = (i == cbt_pkg::RUN_LEN - 1);
                pending_points.push_back(pt);
            end
        endfunction

        // A point left the block: compare it with the oldest expectation.
        task check_point(input logic [39:0] data, input logic last);
            curve_point_t exp_pt;
            if (pending_points.size() == 0)
            begin
                report($sformatf("unexpected point tdata=%h tlast=%b", data, last));
                return;
            end
            exp_pt = pending_points.pop_front();
            if (data[15:0] !== exp_pt.x)
            begin
                report($sformatf("point %0d: point_x %0d, expected %0d", exp_pt.idx,
                                 $signed(data[15:0]), $signed(exp_pt.x)));
            end
            if (data[31:16] !== exp_pt.y)
            begin
                report($sformatf("point %0d: point_y %0d, expected %0d", exp_pt.idx,
                                 $signed(data[31:16]), $signed(exp_pt.y)));
            end
            if (data[37:32] !== exp_pt.idx)
            begin
                report($sformatf("sample_index %0d, expected %0d", data[37:32],
                                 exp_pt.idx));
            end
            if (data[39:38] !== 2'b00)
            begin
                report($sformatf("point %0d: padding bits %b", exp_pt.idx, data[39:38]));
            end
            if (last !== exp_pt.last)
            begin
                report($sformatf("point %0d: last_point %b, expected %b", exp_pt.idx,
                                 last, exp_pt.last));
            end
        endtask

        function int outstanding();
            return pending_points.size();
        endfunction
    endclass

    curve_scoreboard sb;

    cubic_bezier_tessellator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock with a period of 12 time units.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check each transaction and stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_point(m_tdata, m_tlast);
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] pack_curve(input logic [15:0] sx, input logic [15:0] sy,
                                               input logic [15:0] ex, input logic [15:0] ey);
        return {ey, ex, sy, sx};
    endfunction

    // Field value for random curves: mostly uniform, sometimes an extreme.
    function automatic logic [15:0] pick_coord();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Offer one curve, after an optional random gap, and wait for its transaction.
    task automatic send_curve(input logic [63:0] curve);
        int gap;
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= curve;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_curve(curve);
    endtask

    // Hold the sender back until every point owed has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Main sequence: reset, directed curves, random curves, drain.
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        stall_left = 0;
        idling_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed curves: corners of the coordinate range and degenerate shapes.
        send_curve(pack_curve(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
        send_curve(pack_curve(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
        send_curve(pack_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_curve(pack_curve(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        send_curve(pack_curve(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_curve(pack_curve(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_curve(pack_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_curve(pack_curve(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_curve(pack_curve(16'h0000, 16'h0000, 16'h0001, 16'hFFFF));
        send_curve(pack_curve(16'hFFFF, 16'h0001, 16'h0000, 16'h0000));
        send_curve(pack_curve(16'h1234, 16'h8000, 16'hEDCC, 16'h7FFF));
        send_curve(pack_curve(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));

        // Let the pipeline run dry once before the random part.
        wait_drained();

        // Random curves; the final stretch runs without any idling.
        for (int k = 0; k < 100; k++)
        begin
            if (k == 80)
            begin
                idling_on = 1'b0;
            end
            if (k == 40)
            begin
                wait_drained();
            end
            send_curve(pack_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord()));
        end
        s_tvalid <= 1'b0;

        // Drain, then keep watching for any stray point.
        @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (sb.outstanding() != 0)
        begin
            sb.report($sformatf("%0d points never arrived", sb.outstanding()));
        end
        if (sb.mismatch_count == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial
    begin
        #(12 * 400000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
